/* design/two_pkg.sv */
package two_pkg;

    localparam int ANGLE_BITS = 16;

    localparam int CFG_W   = 24;
    localparam int ANG_W   = 32;
    localparam int HEAD_W  = 16;
    localparam int POS_W   = 40;
    localparam int DELTA_W = ANG_W + 1;

    localparam int MUL_A_W   = 57;
    localparam int MUL_B_W   = 33;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_DIG   = 4;
    localparam int MUL_STEPS = (MUL_B_W + MUL_DIG - 1) / MUL_DIG;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    localparam int DW    = 46;
    localparam int SUM_W = 48;

    localparam int WHEEL_SHIFT = 40;
    localparam int OFF_SHIFT   = 28 + ANGLE_BITS;
    localparam int TRIG_SHIFT  = 32;
    localparam logic [MUL_B_W-1:0] WHEEL_K   = MUL_B_W'(95950490);
    localparam logic [MUL_B_W-1:0] TWOPI_Q28 = MUL_B_W'(1686629713);

    localparam int CORDIC_N  = 30;
    localparam int CRD_CNT_W = $clog2(CORDIC_N);
    localparam int CRD_W     = 35;
    localparam int CRDZ_W    = 33;
    localparam int TRIG_W    = 34;
    localparam logic signed [CRD_W-1:0] CORDIC_X0 = CRD_W'(64'd2608131496);

    localparam logic [CFG_W-1:0] DIAM_RESET = CFG_W'(180224);

    typedef enum logic [1:0] {
        CFG_FWD_DIAM = 2'd0,
        CFG_SIDE_DIAM = 2'd1,
        CFG_FWD_OFF = 2'd2,
        CFG_SIDE_OFF = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } t_trig;

    function automatic logic [31:0] atan_lut(input logic [CRD_CNT_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* design/two_if.sv */
interface two_in_if;
    import two_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [ANG_W-1:0]    forward_wheel_angle;
    logic signed [ANG_W-1:0]    side_wheel_angle;
    logic signed [ANG_W-1:0]    unwrapped_rotation;
    logic        [HEAD_W-1:0]   wrapped_heading;

    modport source (
        output valid, forward_wheel_angle, side_wheel_angle, unwrapped_rotation,
        output wrapped_heading,
        input  ready
    );
    modport sink (
        input  valid, forward_wheel_angle, side_wheel_angle, unwrapped_rotation,
        input  wrapped_heading,
        output ready
    );
endinterface

interface two_out_if;
    import two_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic                       primed;

    modport source (output valid, pos_x, pos_y, primed, input ready);
    modport sink (input valid, pos_x, pos_y, primed, output ready);
endinterface

/* design/tracking_wheel_odometry.sv */
// Two-wheel odometry with IMU heading. Each input beat is one sensor sample and yields one
// output beat with the X/Y position in 1/65536 inch; the first sample after reset only
// primes the stored angles and returns the unchanged position with primed low. An
// integrating sample holds the input off until its output beat is registered: twelve products
// on one shared 4-bit-per-cycle multiplier, with the 30-step heading CORDIC running alongside.
// A priming sample goes straight to the output beat. Either one waits longer while the previous
// output beat is still held by the receiver. The user must write wheel geometry registers only
// while idle; the block itself does not enforce this.
module tracking_wheel_odometry (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [two_pkg::CFG_W-1:0]   i_cfg_data,
    two_in_if.sink                      i_in,
    two_out_if.source                   o_out
);
    import two_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_WAIT, S_ACC} t_state;
    typedef enum logic [3:0] {
        OP_F_RAW, OP_F_SCL, OP_S_RAW, OP_S_SCL,
        OP_FO_RAW, OP_FO_SCL, OP_SO_RAW, OP_SO_SCL,
        OP_X_FC, OP_X_SS, OP_Y_FS, OP_Y_SC
    } t_op;

    t_state                     r_state;
    t_op                        r_op;
    logic [CFG_W-1:0]           r_fdiam, r_sdiam;
    logic signed [CFG_W-1:0]    r_foff, r_soff;
    logic signed [ANG_W-1:0]    r_last_f, r_last_s, r_last_rot;
    logic signed [POS_W-1:0]    r_accx, r_accy;
    logic                       r_have, r_primed, r_trig_ok;
    logic signed [DELTA_W-1:0]  r_dfd, r_dsd, r_drot;
    logic [MUL_A_W-1:0]         r_raw;
    logic                       r_raw_neg;
    logic signed [DW-1:0]       r_df, r_ds, r_sx, r_sy;
    logic                       r_out_valid, r_out_primed;
    logic signed [POS_W-1:0]    r_out_x, r_out_y;

    t_mul_req                   mul_req;
    logic                       mul_done;
    logic [PROD_W-1:0]          mul_prod;
    logic                       crd_start, crd_done;
    t_trig                      trig;
    logic [ANG_W-1:0]           crd_angle;
    logic [HEAD_W-1:0]          head_m;

    logic                       in_acc, out_free, mul_go;
    logic [MUL_A_W-1:0]         n_a;
    logic [MUL_B_W-1:0]         n_b;
    logic                       n_neg;
    logic [DELTA_W-1:0]         fmag, smag, rmag;
    logic [CFG_W-1:0]           fomag, somag;
    logic [DW-1:0]              dfmag, dsmag;
    logic [MUL_B_W-1:0]         cmag, smg;
    logic [PROD_W-1:0]          n_r40, n_r44, n_r32;
    logic [DW-1:0]              n_mag;
    logic signed [DW-1:0]       n_val;
    logic signed [SUM_W-1:0]    n_sumx, n_sumy;
    logic signed [POS_W-1:0]    n_accx, n_accy;

    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((64'sd1 <<< (POS_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(64'sd1 <<< (POS_W - 1));

    assign in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free  = !r_out_valid || o_out.ready;
    assign crd_start = in_acc && r_have;
    assign head_m    = i_in.wrapped_heading & HEAD_W'((64'd1 << ANGLE_BITS) - 1);
    assign crd_angle = ANG_W'(ANG_W'(head_m) << (ANG_W - ANGLE_BITS));
    assign mul_go    = (r_state == S_MUL) && (r_op < OP_X_FC || r_trig_ok);

    always_comb begin
        fmag  = r_dfd[DELTA_W-1] ? DELTA_W'(-r_dfd) : DELTA_W'(r_dfd);
        smag  = r_dsd[DELTA_W-1] ? DELTA_W'(-r_dsd) : DELTA_W'(r_dsd);
        rmag  = r_drot[DELTA_W-1] ? DELTA_W'(-r_drot) : DELTA_W'(r_drot);
        fomag = r_foff[CFG_W-1] ? CFG_W'(-r_foff) : CFG_W'(r_foff);
        somag = r_soff[CFG_W-1] ? CFG_W'(-r_soff) : CFG_W'(r_soff);
        dfmag = r_df[DW-1] ? DW'(-r_df) : DW'(r_df);
        dsmag = r_ds[DW-1] ? DW'(-r_ds) : DW'(r_ds);
        cmag  = trig.c[TRIG_W-1] ? MUL_B_W'(-trig.c) : MUL_B_W'(trig.c);
        smg   = trig.s[TRIG_W-1] ? MUL_B_W'(-trig.s) : MUL_B_W'(trig.s);
        case (r_op)
            OP_F_RAW: begin
                n_a = MUL_A_W'(fmag); n_b = MUL_B_W'(r_fdiam); n_neg = r_dfd[DELTA_W-1];
            end
            OP_S_RAW: begin
                n_a = MUL_A_W'(smag); n_b = MUL_B_W'(r_sdiam); n_neg = r_dsd[DELTA_W-1];
            end
            OP_FO_RAW: begin
                n_a = MUL_A_W'(fomag); n_b = rmag;
                n_neg = r_foff[CFG_W-1] ^ r_drot[DELTA_W-1];
            end
            OP_SO_RAW: begin
                n_a = MUL_A_W'(somag); n_b = rmag;
                n_neg = r_soff[CFG_W-1] ^ r_drot[DELTA_W-1];
            end
            OP_F_SCL, OP_S_SCL: begin
                n_a = r_raw; n_b = WHEEL_K; n_neg = r_raw_neg;
            end
            OP_FO_SCL, OP_SO_SCL: begin
                n_a = r_raw; n_b = TWOPI_Q28; n_neg = r_raw_neg;
            end
            OP_X_FC: begin
                n_a = MUL_A_W'(dfmag); n_b = cmag; n_neg = r_df[DW-1] ^ trig.c[TRIG_W-1];
            end
            OP_X_SS: begin
                n_a = MUL_A_W'(dsmag); n_b = smg; n_neg = r_ds[DW-1] ^ trig.s[TRIG_W-1];
            end
            OP_Y_FS: begin
                n_a = MUL_A_W'(dfmag); n_b = smg; n_neg = r_df[DW-1] ^ trig.s[TRIG_W-1];
            end
            OP_Y_SC: begin
                n_a = MUL_A_W'(dsmag); n_b = cmag; n_neg = r_ds[DW-1] ^ trig.c[TRIG_W-1];
            end
            default: begin
                n_a = '0; n_b = '0; n_neg = 1'b0;
            end
        endcase

        n_r40 = (mul_prod + (PROD_W'(1) << (WHEEL_SHIFT - 1))) >> WHEEL_SHIFT;
        n_r44 = (mul_prod + (PROD_W'(1) << (OFF_SHIFT - 1))) >> OFF_SHIFT;
        n_r32 = (mul_prod + (PROD_W'(1) << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
        case (r_op)
            OP_F_SCL, OP_S_SCL:   n_mag = n_r40[DW-1:0];
            OP_FO_SCL, OP_SO_SCL: n_mag = n_r44[DW-1:0];
            default:              n_mag = n_r32[DW-1:0];
        endcase
        n_val = r_raw_neg ? -$signed(n_mag) : $signed(n_mag);

        n_sumx = $signed({{(SUM_W-POS_W){r_accx[POS_W-1]}}, r_accx})
               + $signed({{(SUM_W-DW){r_sx[DW-1]}}, r_sx});
        n_sumy = $signed({{(SUM_W-POS_W){r_accy[POS_W-1]}}, r_accy})
               + $signed({{(SUM_W-DW){r_sy[DW-1]}}, r_sy});
        n_accx = n_sumx > POS_MAX ? POS_MAX[POS_W-1:0]
               : (n_sumx < POS_MIN ? POS_MIN[POS_W-1:0] : n_sumx[POS_W-1:0]);
        n_accy = n_sumy > POS_MAX ? POS_MAX[POS_W-1:0]
               : (n_sumy < POS_MIN ? POS_MIN[POS_W-1:0] : n_sumy[POS_W-1:0]);

        mul_req.start = mul_go;
        mul_req.a     = n_a;
        mul_req.b     = n_b;
    end

    two_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    two_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (crd_start),
        .i_angle (crd_angle),
        .o_done  (crd_done),
        .o_trig  (trig)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_F_RAW;
            r_fdiam     <= DIAM_RESET;
            r_sdiam     <= DIAM_RESET;
            r_foff      <= '0;
            r_soff      <= '0;
            r_last_f    <= '0;
            r_last_s    <= '0;
            r_last_rot  <= '0;
            r_accx      <= '0;
            r_accy      <= '0;
            r_have      <= 1'b0;
            r_primed    <= 1'b0;
            r_trig_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FWD_DIAM:  r_fdiam <= i_cfg_data;
                    CFG_SIDE_DIAM: r_sdiam <= i_cfg_data;
                    CFG_FWD_OFF:   r_foff  <= $signed(i_cfg_data);
                    CFG_SIDE_OFF:  r_soff  <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (crd_done) begin
                r_trig_ok <= 1'b1;
            end
            if (r_out_valid && o_out.ready && r_state != S_ACC) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_dfd <= $signed({i_in.forward_wheel_angle[ANG_W-1],
                                          i_in.forward_wheel_angle})
                               - $signed({r_last_f[ANG_W-1], r_last_f});
                        r_dsd <= $signed({i_in.side_wheel_angle[ANG_W-1],
                                          i_in.side_wheel_angle})
                               - $signed({r_last_s[ANG_W-1], r_last_s});
                        r_drot <= $signed({i_in.unwrapped_rotation[ANG_W-1],
                                           i_in.unwrapped_rotation})
                                - $signed({r_last_rot[ANG_W-1], r_last_rot});
                        r_last_f   <= i_in.forward_wheel_angle;
                        r_last_s   <= i_in.side_wheel_angle;
                        r_last_rot <= i_in.unwrapped_rotation;
                        r_have     <= 1'b1;
                        r_primed   <= r_have;
                        r_op       <= OP_F_RAW;
                        r_trig_ok  <= 1'b0;
                        r_state    <= r_have ? S_MUL : S_ACC;
                    end
                end
                S_MUL: begin
                    if (mul_go) begin
                        r_raw_neg <= n_neg;
                        r_state   <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (mul_done) begin
                        case (r_op)
                            OP_F_RAW, OP_S_RAW, OP_FO_RAW, OP_SO_RAW:
                                r_raw <= mul_prod[MUL_A_W-1:0];
                            OP_F_SCL:  r_df <= n_val;
                            OP_S_SCL:  r_ds <= n_val;
                            OP_FO_SCL: r_df <= r_df - n_val;
                            OP_SO_SCL: r_ds <= r_ds + n_val;
                            OP_X_FC:   r_sx <= n_val;
                            OP_X_SS:   r_sx <= r_sx - n_val;
                            OP_Y_FS:   r_sy <= n_val;
                            OP_Y_SC:   r_sy <= r_sy + n_val;
                            default: ;
                        endcase
                        if (r_op == OP_Y_SC) begin
                            r_state <= S_ACC;
                        end else begin
                            r_op    <= t_op'(r_op + 1'b1);
                            r_state <= S_MUL;
                        end
                    end
                end
                S_ACC: begin
                    if (out_free) begin
                        if (r_primed) begin
                            r_accx  <= n_accx;
                            r_accy  <= n_accy;
                            r_out_x <= n_accx;
                            r_out_y <= n_accy;
                        end else begin
                            r_out_x <= r_accx;
                            r_out_y <= r_accy;
                        end
                        r_out_primed <= r_primed;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.pos_x  = r_out_x;
    assign o_out.pos_y  = r_out_y;
    assign o_out.primed = r_out_primed;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("sample accepted but sequencer stayed idle");

    a_no_mul_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_IDLE && mul_done))
        else $error("multiplier finished while sequencer idle");

    a_out_matches_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_x == r_accx && r_out_y == r_accy))
        else $error("pending beat differs from stored position");

    a_trig_before_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_go && r_op >= OP_X_FC) |-> r_trig_ok)
        else $error("heading product issued before cordic finished");
`endif

endmodule

/* design/two_mul.sv */
module two_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  two_pkg::t_mul_req             i_req,
    output logic                          o_done,
    output logic [two_pkg::PROD_W-1:0]    o_prod
);
    import two_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_a;
    logic [MUL_B_W-1:0]   r_b;
    logic [PROD_W-1:0]    r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= PROD_W'(i_req.a);
                r_b    <= i_req.b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= r_acc + r_a * PROD_W'(r_b[MUL_DIG-1:0]);
                r_a   <= r_a << MUL_DIG;
                r_b   <= r_b >> MUL_DIG;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* design/two_cordic.sv */
module two_cordic (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [two_pkg::ANG_W-1:0]   i_angle,
    output logic                        o_done,
    output two_pkg::t_trig              o_trig
);
    import two_pkg::*;

    typedef enum logic [1:0] {QD_0 = 2'd0, QD_1 = 2'd1, QD_2 = 2'd2, QD_3 = 2'd3} t_quad;

    logic                     r_busy;
    logic                     r_done;
    logic [CRD_CNT_W-1:0]     r_i;
    t_quad                    r_q;
    logic signed [CRD_W-1:0]  r_x;
    logic signed [CRD_W-1:0]  r_y;
    logic signed [CRDZ_W-1:0] r_z;
    t_trig                    r_trig;

    logic signed [CRD_W-1:0]  n_x, n_y, xs, ys;
    logic signed [CRDZ_W-1:0] n_z, at;
    logic [TRIG_W-2:0]        cx, cy;
    t_trig                    n_trig;

    localparam logic signed [CRD_W-1:0] ONE_Q32 = CRD_W'(64'h1_0000_0000);

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = $signed({1'b0, atan_lut(r_i)});
        if (!r_z[CRDZ_W-1]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - at;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + at;
        end
        cx = n_x[CRD_W-1] ? '0 : (n_x > ONE_Q32 ? ONE_Q32[TRIG_W-2:0] : n_x[TRIG_W-2:0]);
        cy = n_y[CRD_W-1] ? '0 : (n_y > ONE_Q32 ? ONE_Q32[TRIG_W-2:0] : n_y[TRIG_W-2:0]);
        case (r_q)
            QD_0: begin
                n_trig.c = $signed({1'b0, cx});
                n_trig.s = $signed({1'b0, cy});
            end
            QD_1: begin
                n_trig.c = -$signed({1'b0, cy});
                n_trig.s = $signed({1'b0, cx});
            end
            QD_2: begin
                n_trig.c = -$signed({1'b0, cx});
                n_trig.s = -$signed({1'b0, cy});
            end
            default: begin
                n_trig.c = $signed({1'b0, cy});
                n_trig.s = -$signed({1'b0, cx});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_q    <= t_quad'(i_angle[ANG_W-1 -: 2]);
                r_x    <= CORDIC_X0;
                r_y    <= '0;
                r_z    <= $signed({3'b000, i_angle[ANG_W-3:0]});
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_i <= r_i + 1'b1;
                if (r_i == CRD_CNT_W'(CORDIC_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_trig <= n_trig;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_trig = r_trig;

endmodule

/* tb/sv/tracking_wheel_odometry_test.sv */
module tracking_wheel_odometry_test;
    import two_pkg::*;

    typedef struct {
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic               primed;
    } t_pos;

    typedef struct {
        logic [31:0] fa;
        logic [31:0] sa;
        logic [31:0] rot;
        logic [15:0] head;
        bit          has_want;
        t_pos        want;
    } t_row;

    localparam longint POS_HI = (64'sd1 <<< 39) - 1;
    localparam longint POS_LO = -(64'sd1 <<< 39);

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    two_in_if in_ch();
    two_out_if out_ch();

    tracking_wheel_odometry dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // predictor state
    logic [23:0] fwd_diam, side_diam, fwd_off, side_off;
    longint last_fa, last_sa, last_rot, acc_x, acc_y;
    bit have_prev;
    t_pos pos_q[$];
    int errors = 0;
    bit hold_long = 0;
    bit sink_go = 0;

    function automatic longint round_mul_shift(longint a, longint k, int s);
        logic [127:0] mag, r;
        bit neg;
        neg = a < 0;
        mag = neg ? 128'(-a) : 128'(a);
        r = (mag * 128'(k) + (128'd1 << (s - 1))) >> s;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint mul_trig(longint a, longint c);
        longint r;
        r = round_mul_shift(a, c < 0 ? -c : c, 32);
        return c < 0 ? -r : r;
    endfunction

    function automatic longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp1(longint v);
        return v < 0 ? 0 : (v > (64'sd1 <<< 32) ? (64'sd1 <<< 32) : v);
    endfunction

    task automatic heading_trig(input logic [31:0] ang, output longint c, output longint s);
        longint x, y, z, nx;
        x = 64'sd2608131496;
        y = 0;
        z = longint'(ang[29:0]);
        for (int i = 0; i < CORDIC_N; i++) begin
            if (z >= 0) begin
                nx = x - asr(y, i);
                y = y + asr(x, i);
                z -= longint'(atan_lut(5'(i)));
            end else begin
                nx = x + asr(y, i);
                y = y - asr(x, i);
                z += longint'(atan_lut(5'(i)));
            end
            x = nx;
        end
        x = clamp1(x);
        y = clamp1(y);
        case (ang[31:30])
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic longint sat_pos(longint v);
        return v > POS_HI ? POS_HI : (v < POS_LO ? POS_LO : v);
    endfunction

    task automatic predict_position(input t_row r, output t_pos p);
        longint fa, sa, rot, drot, df, ds, c, s;
        fa = longint'(signed'(r.fa));
        sa = longint'(signed'(r.sa));
        rot = longint'(signed'(r.rot));
        p.primed = have_prev;
        if (have_prev) begin
            drot = rot - last_rot;
            df = round_mul_shift((fa - last_fa) * longint'(fwd_diam), 95950490, 40);
            ds = round_mul_shift((sa - last_sa) * longint'(side_diam), 95950490, 40);
            df -= round_mul_shift(longint'(signed'(fwd_off)) * drot, 1686629713,
                28 + ANGLE_BITS);
            ds += round_mul_shift(longint'(signed'(side_off)) * drot, 1686629713,
                28 + ANGLE_BITS);
            heading_trig({r.head, 16'd0}, c, s);
            acc_x = sat_pos(acc_x + (mul_trig(df, c) - mul_trig(ds, s)));
            acc_y = sat_pos(acc_y + (mul_trig(df, s) + mul_trig(ds, c)));
        end
        last_fa = fa;
        last_sa = sa;
        last_rot = rot;
        have_prev = 1;
        p.x = acc_x[39:0];
        p.y = acc_y[39:0];
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_FWD_DIAM: fwd_diam = val;
            CFG_SIDE_DIAM: side_diam = val;
            CFG_FWD_OFF: fwd_off = val;
            CFG_SIDE_OFF: side_off = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pos_q.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    // drives one beat, keeps valid high across a burst
    int burst_left = 0;
    task automatic send_sample(input t_row r);
        t_pos p;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
            if (gap > 0) begin
                in_ch.valid <= 0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid <= 1;
        in_ch.forward_wheel_angle <= r.fa;
        in_ch.side_wheel_angle <= r.sa;
        in_ch.unwrapped_rotation <= r.rot;
        in_ch.wrapped_heading <= r.head;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_position(r, p);
        if (r.has_want && (p.x != r.want.x || p.y != r.want.y || p.primed != r.want.primed))
            report_mismatch("directed row", p.x, r.want.x);
        pos_q.push_back(p);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        in_ch.valid <= 0;
        burst_left = 0;
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'h7FFFFFFF - $urandom_range(0, 3);
            2: return 32'h80000000 + $urandom_range(0, 3);
            default: return 32'($urandom_range(0, 20000)) - 32'd10000;
        endcase
    endfunction

    t_row rows[$];
    t_row r;
    logic [31:0] base_f, base_s, base_r;

    initial begin
        in_ch.valid = 0;
        in_ch.forward_wheel_angle = '0;
        in_ch.side_wheel_angle = '0;
        in_ch.unwrapped_rotation = '0;
        in_ch.wrapped_heading = '0;
        fwd_diam = DIAM_RESET;
        side_diam = DIAM_RESET;
        fwd_off = '0;
        side_off = '0;
        {last_fa, last_sa, last_rot, acc_x, acc_y} = '0;
        have_prev = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        sink_go <= 1;

        // directed table
        rows = '{
            '{32'd12345, 32'd0, 32'd0, 16'd0, 1, '{40'sd0, 40'sd0, 1'b0}},
            '{32'd12345, 32'd0, 32'd0, 16'd0, 1, '{40'sd0, 40'sd0, 1'b1}},
            '{32'd48345, 32'd0, 32'd0, 16'd0, 0, '{0, 0, 0}},
            '{32'd48345, 32'd36000, 32'd0, 16'h4000, 0, '{0, 0, 0}},
            '{32'h7FFFFFFF, 32'h80000000, 32'd100, 16'h8000, 0, '{0, 0, 0}},
            '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hC000, 0, '{0, 0, 0}},
            '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 0, '{0, 0, 0}},
            '{32'd0, 32'd0, 32'd0, 16'h2000, 0, '{0, 0, 0}},
            '{32'd1, 32'hFFFFFFFF, 32'd1, 16'h0001, 0, '{0, 0, 0}},
            '{32'hFFFFFFFF, 32'd1, 32'hFFFFFFFF, 16'h5555, 0, '{0, 0, 0}},
            '{32'd0, 32'd0, 32'd0, 16'hAAAA, 0, '{0, 0, 0}}
        };
        foreach (rows[i]) send_sample(rows[i]);
        end_burst();
        wait_idle();

        // extreme geometry, drive position into saturation
        write_reg(CFG_FWD_DIAM, 24'hFFFFFF);
        write_reg(CFG_SIDE_DIAM, 24'hFFFFFF);
        write_reg(CFG_FWD_OFF, 24'h7FFFFF);
        write_reg(CFG_SIDE_OFF, 24'h800000);
        write_reg(CFG_SIDE_OFF, 24'h800000);
        for (int k = 0; k < 14; k++) begin
            r = '{k[0] ? 32'h7FFFFFFF : 32'h80000001, k[0] ? 32'h80000000 : 32'h7FFFFFFF,
                  k[0] ? 32'h7FFFFFFF : 32'h80000000, k < 7 ? 16'h0000 : 16'h8000,
                  0, '{0, 0, 0}};
            send_sample(r);
        end
        end_burst();
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_FWD_DIAM, 24'd0);
                    write_reg(CFG_SIDE_DIAM, 24'd0);
                    write_reg(CFG_FWD_OFF, 24'd0);
                    write_reg(CFG_SIDE_OFF, 24'd0);
                end
                1: begin
                    write_reg(CFG_FWD_DIAM, DIAM_RESET);
                    write_reg(CFG_SIDE_DIAM, 24'd131072);
                    write_reg(CFG_FWD_OFF, 24'($urandom()));
                    write_reg(CFG_SIDE_OFF, 24'($urandom()));
                end
                default: begin
                    write_reg(CFG_FWD_DIAM, 24'($urandom()));
                    write_reg(CFG_SIDE_DIAM, 24'($urandom()));
                    write_reg(CFG_FWD_OFF, 24'($urandom()));
                    write_reg(CFG_SIDE_OFF, 24'($urandom()));
                end
            endcase
            if (ph == 2) hold_long <= 1;
            base_f = $urandom();
            base_s = $urandom();
            base_r = $urandom();
            for (int k = 0; k < 205; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    r.fa = rand_angle();
                    r.sa = rand_angle();
                    r.rot = rand_angle();
                end else begin
                    base_f += 32'($urandom_range(0, 4000)) - 32'd2000;
                    base_s += 32'($urandom_range(0, 4000)) - 32'd2000;
                    base_r += 32'($urandom_range(0, 2000)) - 32'd1000;
                    r.fa = base_f;
                    r.sa = base_s;
                    r.rot = base_r;
                end
                r.head = 16'($urandom());
                r.has_want = 0;
                send_sample(r);
            end
            end_burst();
            wait_idle();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: own stall pattern, one long hold-off
    initial begin
        int hold;
        out_ch.ready = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_long && hold == 0) begin
                hold = 3000;
                hold_long = 0;
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 0;
            end else begin
                out_ch.ready <= sink_go && ($urandom_range(0, 9) < 7);
            end
        end
    end

    always @(posedge i_clk) begin
        t_pos w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pos_q.size() == 0) begin
                report_mismatch("unexpected beat", out_ch.pos_x, 0);
            end else begin
                w = pos_q.pop_front();
                if (out_ch.pos_x !== w.x) report_mismatch("pos_x", out_ch.pos_x, w.x);
                if (out_ch.pos_y !== w.y) report_mismatch("pos_y", out_ch.pos_y, w.y);
                if (out_ch.primed !== w.primed)
                    report_mismatch("primed", out_ch.primed, w.primed);
            end
        end
    end

    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
